### rtl/rc_frame_decode_axis_mapper_top_assert.svh
// Assertion macros for the remote-control frame decoder checker.
// Both macros expect signals named clk and rst in the scope of use.
`ifndef RC_FRAME_DECODE_AXIS_MAPPER_TOP_ASSERT_SVH
`define RC_FRAME_DECODE_AXIS_MAPPER_TOP_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define RCFD_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rcfd port check failed");

// Checks a property on every clock edge, reset included.
`define RCFD_CHECK_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rcfd reset check failed");

`endif

### rtl/rcfd_pkg.sv
// Shared types and constants of the remote-control frame decoder.
// No dependencies; used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

  localparam int BYTE_W        = 8;
  localparam int FRAME_BYTES   = 18;
  localparam int COUNT_W       = 5;
  localparam int CENTER_OFFSET = 1024;
  localparam int RAW_W         = 11;
  localparam int WHEEL_W       = 16;
  localparam int VALUE_W       = 17;
  localparam int MAG_W         = 16;
  localparam int TRIAL_W       = 12;

  localparam int SCALE_W     = 11;
  localparam int LIMIT_W     = 10;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_STICK_FULL_SCALE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GANTRY_Z_LIMIT   = 1'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 11'd660;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHASSIS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARM     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GANTRY  = 2'd3;

  localparam int NUM_VALUES = 5;
  localparam int SEL_W      = 3;
  localparam logic [SEL_W-1:0] VAL_RX    = 3'd0;
  localparam logic [SEL_W-1:0] VAL_RY    = 3'd1;
  localparam logic [SEL_W-1:0] VAL_LX    = 3'd2;
  localparam logic [SEL_W-1:0] VAL_LY    = 3'd3;
  localparam logic [SEL_W-1:0] VAL_WHEEL = 3'd4;

  localparam int SPEED_W   = 16;
  localparam int ACC_OUT_W = 32;
  localparam int GZ_OUT_W  = 25;

  typedef struct packed {
    logic             take;
    logic             div_load;
    logic             div_step;
    logic             q_store;
    logic             commit;
    logic [SEL_W-1:0] sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic frame_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/rcfd_ctrl.sv
// Controller of the frame decoder: byte intake, divider sequencing and result commit.
// Depends on rcfd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_ctrl #(
  parameter int FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rcfd_pkg::dp_status_t status,
  output rcfd_pkg::ctl_cmd_t   cmd
);
  import rcfd_pkg::*;

  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_LOAD    = 3'd1;
  localparam logic [2:0] S_DIV     = 3'd2;
  localparam logic [2:0] S_STORE   = 3'd3;
  localparam logic [2:0] S_COMMIT  = 3'd4;

  logic [2:0]        state, state_next;
  logic [SEL_W-1:0]  sel, sel_next;
  logic [STEP_W-1:0] bit_cnt, bit_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_COLLECT;
      sel     <= '0;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      sel     <= sel_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    sel_next     = sel;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    cmd.sel      = sel;
    in_ready     = (state == S_COLLECT);
    unique case (state)
      S_COLLECT: begin
        cmd.take = in_valid;
        if (in_valid && status.frame_last) begin
          sel_next   = '0;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        bit_cnt_next = STEP_W'(FRAC_BITS);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_cnt == '0) begin
          state_next = S_STORE;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      S_STORE: begin
        cmd.q_store = 1'b1;
        if (sel == SEL_W'(NUM_VALUES - 1)) begin
          state_next = S_COMMIT;
        end else begin
          sel_next   = sel + 1'b1;
          state_next = S_LOAD;
        end
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_COLLECT;
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/rcfd_datapath.sv
// Datapath of the frame decoder: frame store, shared restoring divider,
// accumulators, configuration registers and the output register.
// Depends on rcfd_pkg; driven by rcfd_ctrl through ctl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_datapath #(
  parameter int FRAC_BITS = 14,
  parameter int ACC_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rcfd_pkg::ctl_cmd_t                     cmd,
  output rcfd_pkg::dp_status_t                   status,
  input  logic                                   cfg_we,
  input  logic [rcfd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [rcfd_pkg::BYTE_W-1:0]            rx_byte,
  input  logic                                   frame_end,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [rcfd_pkg::MODE_W-1:0]            drive_mode,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_vx,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_vy,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_turn_speed,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    claw_angle,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  wrist_yaw,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  wrist_pitch,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  elbow_pitch,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  elbow_yaw,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    gantry_x,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    gantry_y,
  output logic signed [rcfd_pkg::GZ_OUT_W-1:0]   gantry_z
);
  import rcfd_pkg::*;

  localparam int QW     = FRAC_BITS + 2;
  localparam int QMAG_W = FRAC_BITS + 1;
  localparam int GZ_W   = LIMIT_W + FRAC_BITS + 1;
  localparam logic [QMAG_W-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [SPEED_W-1:0] fit_speed(input logic signed [QW-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[SPEED_W-1:0];
  endfunction

  function automatic logic [ACC_OUT_W-1:0] fit_acc(input logic signed [ACC_WIDTH-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[ACC_OUT_W-1:0];
  endfunction

  function automatic logic [GZ_OUT_W-1:0] fit_gz(input logic signed [GZ_W-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[GZ_OUT_W-1:0];
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [QW-1:0]        d
  );
    logic signed [ACC_WIDTH:0] s;
    s = (ACC_WIDTH + 1)'(a) + (ACC_WIDTH + 1)'(d);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                          : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  // Configuration registers.
  logic [SCALE_W-1:0] stick_full_scale;
  logic [LIMIT_W-1:0] gantry_z_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_full_scale <= SCALE_RESET;
      gantry_z_limit   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STICK_FULL_SCALE: stick_full_scale <= cfg_data;
        REG_GANTRY_Z_LIMIT:   gantry_z_limit   <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  // Byte intake.
  logic [COUNT_W-1:0] byte_count;
  logic [BYTE_W-1:0]  frame_store [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (cmd.take) begin
      if (frame_end) begin
        byte_count <= '0;
      end else if (byte_count < COUNT_W'(FRAME_BYTES)) begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && (byte_count < COUNT_W'(FRAME_BYTES))) begin
      frame_store[byte_count] <= rx_byte;
    end
  end

  assign status.frame_last = frame_end && (byte_count >= COUNT_W'(FRAME_BYTES - 1));
  assign status.out_free   = !out_valid || out_ready;

  // Field extraction from the stored frame.
  logic [RAW_W-1:0]          raw_rx, raw_ry, raw_lx, raw_ly;
  logic [WHEEL_W-1:0]        wheel_raw;
  logic [MODE_W-1:0]         frame_mode;
  logic signed [VALUE_W-1:0] val_sel;
  logic [MAG_W-1:0]          mag;

  assign raw_rx     = {frame_store[1][2:0], frame_store[0]};
  assign raw_ry     = {frame_store[2][5:0], frame_store[1][7:3]};
  assign raw_lx     = {frame_store[4][0], frame_store[3], frame_store[2][7:6]};
  assign raw_ly     = {frame_store[5][3:0], frame_store[4][7:1]};
  assign frame_mode = frame_store[5][7:6];
  assign wheel_raw  = {frame_store[17], frame_store[16]} - WHEEL_W'(CENTER_OFFSET);

  always_comb begin
    unique case (cmd.sel)
      VAL_RX:    val_sel = VALUE_W'($signed({1'b0, raw_rx})) - VALUE_W'(CENTER_OFFSET);
      VAL_RY:    val_sel = VALUE_W'($signed({1'b0, raw_ry})) - VALUE_W'(CENTER_OFFSET);
      VAL_LX:    val_sel = VALUE_W'($signed({1'b0, raw_lx})) - VALUE_W'(CENTER_OFFSET);
      VAL_LY:    val_sel = VALUE_W'($signed({1'b0, raw_ly})) - VALUE_W'(CENTER_OFFSET);
      VAL_WHEEL: val_sel = VALUE_W'($signed(wheel_raw));
      default:   val_sel = '0;
    endcase
  end

  assign mag = val_sel[VALUE_W-1] ? MAG_W'(-val_sel) : MAG_W'(val_sel);

  // Shared restoring divider, one quotient bit per cycle.
  logic [TRIAL_W-1:0] trial, rem;
  logic [QMAG_W-1:0]  qacc, qmag;
  logic               q_neg, q_sat, q_zero, ge;
  logic [QW-1:0]      q_pos;
  logic signed [QW-1:0] q_signed;

  assign ge  = trial >= TRIAL_W'(stick_full_scale);
  assign rem = ge ? trial - TRIAL_W'(stick_full_scale) : trial;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_neg <= val_sel[VALUE_W-1];
      trial <= mag[TRIAL_W-1:0];
      qacc  <= '0;
      if (stick_full_scale == '0) begin
        q_sat  <= (mag != '0);
        q_zero <= (mag == '0);
      end else begin
        q_sat  <= (mag >= MAG_W'({stick_full_scale, 1'b0}));
        q_zero <= 1'b0;
      end
    end else if (cmd.div_step) begin
      trial <= {rem[TRIAL_W-2:0], 1'b0};
      qacc  <= {qacc[QMAG_W-2:0], ge};
    end
  end

  always_comb begin
    if (q_zero) begin
      qmag = '0;
    end else if (q_sat || (qacc > Q_ONE)) begin
      qmag = Q_ONE;
    end else begin
      qmag = qacc;
    end
    q_pos    = {1'b0, qmag};
    q_signed = q_neg ? -$signed(q_pos) : $signed(q_pos);
  end

  logic signed [QW-1:0] qv [NUM_VALUES];

  always_ff @(posedge clk) begin
    if (cmd.q_store) begin
      qv[cmd.sel] <= q_signed;
    end
  end

  // Accumulators and mode routing.
  logic signed [ACC_WIDTH-1:0] wrist_yaw_sum, wrist_pitch_sum, elbow_pitch_sum, elbow_yaw_sum;
  logic signed [ACC_WIDTH-1:0] wy_next, wp_next, ep_next, ey_next;
  logic signed [GZ_W-1:0]      gantry_z_sum, gz_next;
  logic signed [GZ_W:0]        gz_raw, gz_lim;

  always_comb begin
    wy_next = sat_add(wrist_yaw_sum, qv[VAL_WHEEL]);
    wp_next = sat_add(wrist_pitch_sum, qv[VAL_RY]);
    ep_next = sat_add(elbow_pitch_sum, qv[VAL_LY]);
    ey_next = sat_add(elbow_yaw_sum, qv[VAL_LX]);
    gz_lim  = (GZ_W + 1)'($signed({1'b0, gantry_z_limit, {FRAC_BITS{1'b0}}}));
    gz_raw  = (GZ_W + 1)'(gantry_z_sum) + (GZ_W + 1)'(qv[VAL_RY]);
    if (gz_raw > gz_lim) begin
      gz_next = gz_lim[GZ_W-1:0];
    end else if (gz_raw < -gz_lim) begin
      gz_next = GZ_W'(-gz_lim);
    end else begin
      gz_next = gz_raw[GZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrist_yaw_sum   <= '0;
      wrist_pitch_sum <= '0;
      elbow_pitch_sum <= '0;
      elbow_yaw_sum   <= '0;
      gantry_z_sum    <= '0;
    end else if (cmd.commit) begin
      if (frame_mode == MODE_ARM) begin
        wrist_yaw_sum   <= wy_next;
        wrist_pitch_sum <= wp_next;
        elbow_pitch_sum <= ep_next;
        elbow_yaw_sum   <= ey_next;
      end
      if (frame_mode == MODE_GANTRY) begin
        gantry_z_sum <= gz_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      drive_mode         <= frame_mode;
      chassis_vx         <= '0;
      chassis_vy         <= '0;
      chassis_turn_speed <= '0;
      claw_angle         <= '0;
      wrist_yaw          <= '0;
      wrist_pitch        <= '0;
      elbow_pitch        <= '0;
      elbow_yaw          <= '0;
      gantry_x           <= '0;
      gantry_y           <= '0;
      gantry_z           <= '0;
      unique case (frame_mode)
        MODE_NONE: begin
        end
        MODE_CHASSIS: begin
          chassis_vx         <= fit_speed(qv[VAL_LX]);
          chassis_vy         <= fit_speed(-qv[VAL_LY]);
          chassis_turn_speed <= fit_speed(qv[VAL_WHEEL]);
        end
        MODE_ARM: begin
          claw_angle  <= fit_speed(-qv[VAL_RX]);
          wrist_yaw   <= fit_acc(wy_next);
          wrist_pitch <= fit_acc(wp_next);
          elbow_pitch <= fit_acc(ep_next);
          elbow_yaw   <= fit_acc(ey_next);
        end
        MODE_GANTRY: begin
          gantry_x <= fit_speed(qv[VAL_LY]);
          gantry_y <= fit_speed(qv[VAL_LX]);
          gantry_z <= fit_gz(gz_next);
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rc_frame_decode_axis_mapper_top.sv
// Top level of the remote-control frame decoder and axis mapper.
// Instantiates rcfd_ctrl and rcfd_datapath; depends on rcfd_pkg.
//
//   Channel   Handshake             Payload
//   input     in_valid/in_ready     rx_byte, frame_end
//   result    out_valid/out_ready   drive_mode and the eleven axis fields
//   config    cfg_we                cfg_index, cfg_data
//
// A byte that does not complete a frame leaves input ready high.
// The last byte of a full frame starts five normalizing divisions on one shared
// restoring divider, each through the load, divide and store states, and input ready
// stays low through them and the commit, which waits while the prior result is still held.
// Reset is synchronous and needs no clearing pass; the frame store is never read unwritten.
`timescale 1ns / 1ps
`default_nettype none

module rc_frame_decode_axis_mapper_top #(
  parameter int FRAC_BITS = 14,
  parameter int ACC_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [rcfd_pkg::BYTE_W-1:0]            rx_byte,
  input  logic                                   frame_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rcfd_pkg::MODE_W-1:0]            drive_mode,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_vx,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_vy,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_turn_speed,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    claw_angle,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  wrist_yaw,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  wrist_pitch,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  elbow_pitch,
  output logic signed [rcfd_pkg::ACC_OUT_W-1:0]  elbow_yaw,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    gantry_x,
  output logic signed [rcfd_pkg::SPEED_W-1:0]    gantry_y,
  output logic signed [rcfd_pkg::GZ_OUT_W-1:0]   gantry_z,
  input  logic                                   cfg_we,
  input  logic [rcfd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import rcfd_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  rcfd_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcfd_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .rx_byte            (rx_byte),
    .frame_end          (frame_end),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .drive_mode         (drive_mode),
    .chassis_vx         (chassis_vx),
    .chassis_vy         (chassis_vy),
    .chassis_turn_speed (chassis_turn_speed),
    .claw_angle         (claw_angle),
    .wrist_yaw          (wrist_yaw),
    .wrist_pitch        (wrist_pitch),
    .elbow_pitch        (elbow_pitch),
    .elbow_yaw          (elbow_yaw),
    .gantry_x           (gantry_x),
    .gantry_y           (gantry_y),
    .gantry_z           (gantry_z)
  );

endmodule

`default_nettype wire

### rtl/rcfd_checker.sv
// Port-level checker for the frame decoder top level, attached by bind.
// Depends on rcfd_pkg and the macros in rc_frame_decode_axis_mapper_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rc_frame_decode_axis_mapper_top_assert.svh"

module rcfd_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [rcfd_pkg::MODE_W-1:0]            drive_mode,
  input logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_vx,
  input logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_vy,
  input logic signed [rcfd_pkg::SPEED_W-1:0]    chassis_turn_speed,
  input logic signed [rcfd_pkg::SPEED_W-1:0]    claw_angle,
  input logic signed [rcfd_pkg::ACC_OUT_W-1:0]  wrist_yaw,
  input logic signed [rcfd_pkg::ACC_OUT_W-1:0]  wrist_pitch,
  input logic signed [rcfd_pkg::ACC_OUT_W-1:0]  elbow_pitch,
  input logic signed [rcfd_pkg::ACC_OUT_W-1:0]  elbow_yaw,
  input logic signed [rcfd_pkg::SPEED_W-1:0]    gantry_x,
  input logic signed [rcfd_pkg::SPEED_W-1:0]    gantry_y,
  input logic signed [rcfd_pkg::GZ_OUT_W-1:0]   gantry_z
);
  import rcfd_pkg::*;

  // A held result keeps its payload until the transfer.
  `RCFD_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(drive_mode) && $stable(wrist_yaw) && $stable(gantry_z))

  // Reset leaves no result pending and the byte input open.
  `RCFD_CHECK_RST(a_reset_idle, rst |=> !out_valid && in_ready)

  // Fields of a mode that is not selected read as zero.
  `RCFD_CHECK(a_chassis_route, out_valid && drive_mode != MODE_CHASSIS |-> chassis_vx == '0 && chassis_vy == '0 && chassis_turn_speed == '0)

  `RCFD_CHECK(a_arm_route, out_valid && drive_mode != MODE_ARM |-> claw_angle == '0 && wrist_yaw == '0 && wrist_pitch == '0 && elbow_pitch == '0 && elbow_yaw == '0)

  `RCFD_CHECK(a_gantry_route, out_valid && drive_mode != MODE_GANTRY |-> gantry_x == '0 && gantry_y == '0 && gantry_z == '0)

endmodule

bind rc_frame_decode_axis_mapper_top rcfd_checker u_rcfd_checker (.*);

`default_nettype wire

### tb/sv/rc_frame_decode_axis_mapper_top_test.sv
// Testbench for rc_frame_decode_axis_mapper_top: streams receiver bytes, predicts each
// decoded frame in the bench and compares every result transfer field by field.
// Depends on rcfd_pkg and the top level only.
`timescale 1ns / 1ps

module rc_frame_decode_axis_mapper_top_test;
  import rcfd_pkg::*;

  localparam int       Q_FRAC      = 14;
  localparam longint   Q_ONE       = 64'sd1 << Q_FRAC;
  localparam longint   ACC_MAX     = 64'sd2147483647;
  localparam longint   ACC_MIN     = -64'sd2147483648;
  localparam int       STALL_LIMIT = 4000;
  localparam int       SETTLE      = 120;

  typedef struct packed {
    logic [MODE_W-1:0]           mode;
    logic signed [SPEED_W-1:0]   cx;
    logic signed [SPEED_W-1:0]   cy;
    logic signed [SPEED_W-1:0]   turn;
    logic signed [SPEED_W-1:0]   claw;
    logic signed [ACC_OUT_W-1:0] w_yaw;
    logic signed [ACC_OUT_W-1:0] w_pitch;
    logic signed [ACC_OUT_W-1:0] e_pitch;
    logic signed [ACC_OUT_W-1:0] e_yaw;
    logic signed [SPEED_W-1:0]   gx;
    logic signed [SPEED_W-1:0]   gy;
    logic signed [GZ_OUT_W-1:0]  gz;
  } axis_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MODE_W-1:0] drive_mode;
  logic signed [SPEED_W-1:0] chassis_vx, chassis_vy, chassis_turn_speed, claw_angle;
  logic signed [ACC_OUT_W-1:0] wrist_yaw, wrist_pitch, elbow_pitch, elbow_yaw;
  logic signed [SPEED_W-1:0] gantry_x, gantry_y;
  logic signed [GZ_OUT_W-1:0] gantry_z;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_STICK_FULL_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the block state and its registers.
  int unsigned  full_scale = 32'(SCALE_RESET);
  int unsigned  z_limit = 32'(LIMIT_RESET);
  int           rx_count = 0;
  logic [7:0]   rx_frame [0:FRAME_BYTES-1];
  longint       wy_model = 0, wp_model = 0, ep_model = 0;
  longint       ey_model = 0, gz_model = 0;

  axis_result_t pending_axes[$];
  int           mismatches = 0;
  int           bytes_sent = 0;
  int           idle_cycles = 0;
  int           ready_hold = 0;
  bit           in_idle_on = 1'b1;
  bit           out_idle_on = 1'b1;

  rc_frame_decode_axis_mapper_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready), .drive_mode(drive_mode),
    .chassis_vx(chassis_vx), .chassis_vy(chassis_vy),
    .chassis_turn_speed(chassis_turn_speed), .claw_angle(claw_angle),
    .wrist_yaw(wrist_yaw), .wrist_pitch(wrist_pitch), .elbow_pitch(elbow_pitch),
    .elbow_yaw(elbow_yaw), .gantry_x(gantry_x), .gantry_y(gantry_y), .gantry_z(gantry_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint norm_q14(input int v, input int unsigned scale);
    longint mag, q;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    if (scale == 0) q = (mag != 0) ? Q_ONE : 0;
    else q = (mag << Q_FRAC) / longint'(scale);
    if (q > Q_ONE) q = Q_ONE;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint sat_acc(input longint a, input longint d);
    longint s;
    s = a + d;
    if (s > ACC_MAX) s = ACC_MAX;
    if (s < ACC_MIN) s = ACC_MIN;
    return s;
  endfunction

  task automatic decode_frame_byte(input logic [7:0] b, input logic last);
    logic [RAW_W-1:0] r0, r1, r2, r3;
    logic [MODE_W-1:0] m;
    int wh;
    longint rx, ry, lx, ly, wq, zlim;
    axis_result_t res;
    if (rx_count < FRAME_BYTES) begin
      rx_frame[rx_count] = b;
      rx_count++;
    end
    if (!last) return;
    if (rx_count < FRAME_BYTES) begin
      rx_count = 0;
      return;
    end
    rx_count = 0;
    r0 = {rx_frame[1][2:0], rx_frame[0]};
    r1 = {rx_frame[2][5:0], rx_frame[1][7:3]};
    r2 = {rx_frame[4][0], rx_frame[3], rx_frame[2][7:6]};
    r3 = {rx_frame[5][3:0], rx_frame[4][7:1]};
    m = rx_frame[5][7:6];
    wh = int'($signed({rx_frame[17], rx_frame[16]})) - CENTER_OFFSET;
    if (wh < -32768) wh += 65536;
    rx = norm_q14(int'(r0) - CENTER_OFFSET, full_scale);
    ry = norm_q14(int'(r1) - CENTER_OFFSET, full_scale);
    lx = norm_q14(int'(r2) - CENTER_OFFSET, full_scale);
    ly = norm_q14(int'(r3) - CENTER_OFFSET, full_scale);
    wq = norm_q14(wh, full_scale);
    res = '0;
    res.mode = m;
    case (m)
      MODE_CHASSIS: begin
        res.cx = SPEED_W'(lx);
        res.cy = SPEED_W'(-ly);
        res.turn = SPEED_W'(wq);
      end
      MODE_ARM: begin
        res.claw = SPEED_W'(-rx);
        wy_model = sat_acc(wy_model, wq);
        wp_model = sat_acc(wp_model, ry);
        ep_model = sat_acc(ep_model, ly);
        ey_model = sat_acc(ey_model, lx);
        res.w_yaw = ACC_OUT_W'(wy_model);
        res.w_pitch = ACC_OUT_W'(wp_model);
        res.e_pitch = ACC_OUT_W'(ep_model);
        res.e_yaw = ACC_OUT_W'(ey_model);
      end
      MODE_GANTRY: begin
        res.gx = SPEED_W'(ly);
        res.gy = SPEED_W'(lx);
        zlim = longint'(z_limit) << Q_FRAC;
        gz_model += ry;
        if (gz_model > zlim) gz_model = zlim;
        if (gz_model < -zlim) gz_model = -zlim;
        res.gz = GZ_OUT_W'(gz_model);
      end
      default: ;
    endcase
    pending_axes.push_back(res);
  endtask

  task automatic field_check(input string name, input longint want, input longint got);
    if (want != got) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    axis_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_axes.size() == 0) begin
        if (mismatches < 10) $display("result transfer with no frame pending");
        mismatches++;
      end else begin
        want = pending_axes.pop_front();
        field_check("drive_mode", longint'(want.mode), longint'(drive_mode));
        field_check("chassis_vx", longint'(want.cx), longint'(chassis_vx));
        field_check("chassis_vy", longint'(want.cy), longint'(chassis_vy));
        field_check("chassis_turn_speed", longint'(want.turn), longint'(chassis_turn_speed));
        field_check("claw_angle", longint'(want.claw), longint'(claw_angle));
        field_check("wrist_yaw", longint'(want.w_yaw), longint'(wrist_yaw));
        field_check("wrist_pitch", longint'(want.w_pitch), longint'(wrist_pitch));
        field_check("elbow_pitch", longint'(want.e_pitch), longint'(elbow_pitch));
        field_check("elbow_yaw", longint'(want.e_yaw), longint'(elbow_yaw));
        field_check("gantry_x", longint'(want.gx), longint'(gantry_x));
        field_check("gantry_y", longint'(want.gy), longint'(gantry_y));
        field_check("gantry_z", longint'(want.gz), longint'(gantry_z));
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (in_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    frame_end = last;
    do @(posedge clk); while (!in_ready);
    decode_frame_byte(b, last);
    bytes_sent++;
  endtask

  // Lowers valid and waits until every pending frame has been delivered.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_axes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    drain_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_STICK_FULL_SCALE) full_scale = value & 32'h7FF;
    else z_limit = value & 32'h3FF;
  endtask

  task automatic send_frame(input logic [RAW_W-1:0] r0, r1, r2, r3,
                            input logic [MODE_W-1:0] m, input logic [15:0] wheel,
                            input int len);
    logic [47:0] packed_sticks;
    logic [1:0] spare;
    logic [7:0] b;
    int i;
    spare = 2'($urandom_range(0, 3));
    packed_sticks = {m, spare, r3, r2, r1, r0};
    for (i = 0; i < len; i++) begin
      if (i < 6) b = packed_sticks[i*8 +: 8];
      else if (i == 16) b = wheel[7:0];
      else if (i == 17) b = wheel[15:8];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 3))
      0: return RAW_W'($urandom_range(0, 2047));
      1: case ($urandom_range(0, 2))
           0: return 11'd0;
           1: return 11'd2047;
           default: return 11'd1024;
         endcase
      default: return 11'(324 + $urandom_range(0, 1400));
    endcase
  endfunction

  function automatic logic [15:0] pick_wheel();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: case ($urandom_range(0, 4))
           0: return 16'h0000;
           1: return 16'hFFFF;
           2: return 16'h7FFF;
           3: return 16'h8000;
           default: return 16'h0400;
         endcase
      default: return 16'(324 + $urandom_range(0, 1400));
    endcase
  endfunction

  task automatic send_random_frame(input int len);
    logic [MODE_W-1:0] m;
    m = MODE_W'($urandom_range(0, 3));
    send_frame(pick_raw(), pick_raw(), pick_raw(), pick_raw(), m, pick_wheel(), len);
  endtask

  // Mostly well-formed frames; some long, short and stray bytes.
  task automatic send_random_buffer();
    int p, n, i;
    logic last;
    p = $urandom_range(0, 99);
    if (p < 80) begin
      send_random_frame(FRAME_BYTES);
    end else if (p < 88) begin
      send_random_frame($urandom_range(FRAME_BYTES + 1, 24));
    end else if (p < 96) begin
      send_random_frame($urandom_range(1, FRAME_BYTES - 1));
    end else begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
        last = 1'($urandom_range(0, 1));
        send_byte(8'($urandom_range(0, 255)), last);
      end
    end
  endtask

  task automatic test_modes();
    send_frame(11'd2047, 11'd0, 11'd2047, 11'd0, MODE_NONE, 16'hFFFF, FRAME_BYTES);
    send_frame(11'd2047, 11'd2047, 11'd2047, 11'd2047, MODE_CHASSIS, 16'h7FFF, FRAME_BYTES);
    send_frame(11'd0, 11'd0, 11'd0, 11'd0, MODE_CHASSIS, 16'h8000, FRAME_BYTES);
    send_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, MODE_CHASSIS, 16'h0400, FRAME_BYTES);
    send_frame(11'd1354, 11'd694, 11'd1684, 11'd364, MODE_ARM, 16'h054A, FRAME_BYTES);
    send_frame(11'd0, 11'd2047, 11'd0, 11'd2047, MODE_ARM, 16'h0000, FRAME_BYTES);
    send_frame(11'd1500, 11'd2047, 11'd900, 11'd1100, MODE_GANTRY, 16'h0400, FRAME_BYTES);
    send_frame(11'd1024, 11'd0, 11'd2047, 11'd0, MODE_GANTRY, 16'h0400, FRAME_BYTES);
  endtask

  task automatic test_buffer_lengths();
    send_frame(11'd1200, 11'd1024, 11'd1024, 11'd1024, MODE_CHASSIS, 16'h0400, 1);
    send_frame(11'd1200, 11'd1024, 11'd1024, 11'd1024, MODE_CHASSIS, 16'h0400, 17);
    send_frame(11'd1100, 11'd1300, 11'd700, 11'd1900, MODE_CHASSIS, 16'h0600, FRAME_BYTES);
    send_frame(11'd800, 11'd1400, 11'd1600, 11'd600, MODE_ARM, 16'h0200, 24);
    send_frame(11'd900, 11'd1800, 11'd1100, 11'd1000, MODE_GANTRY, 16'h0500, 19);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_STICK_FULL_SCALE, 0);
    write_reg(REG_GANTRY_Z_LIMIT, 0);
    send_frame(11'd1024, 11'd1025, 11'd1023, 11'd1024, MODE_CHASSIS, 16'h0401, FRAME_BYTES);
    send_frame(11'd1025, 11'd2047, 11'd1024, 11'd1023, MODE_GANTRY, 16'h0400, FRAME_BYTES);
    send_frame(11'd1023, 11'd1024, 11'd1025, 11'd0, MODE_ARM, 16'h03FF, FRAME_BYTES);
    write_reg(REG_STICK_FULL_SCALE, 1);
    write_reg(REG_GANTRY_Z_LIMIT, 1023);
    send_frame(11'd1025, 11'd2047, 11'd1024, 11'd1023, MODE_GANTRY, 16'h0400, FRAME_BYTES);
    send_frame(11'd1024, 11'd1025, 11'd1023, 11'd1024, MODE_ARM, 16'h0401, FRAME_BYTES);
  endtask

  task automatic test_register_sweep();
    int unsigned scales [6];
    int unsigned limits [6];
    int s, k;
    scales = '{1, 2047, 0, 3, 660, 1};
    limits = '{0, 1000, 1, 5, 100, 1023};
    scales[3] = $urandom_range(1, 2047);
    for (s = 0; s < 6; s++) begin
      write_reg(REG_STICK_FULL_SCALE, scales[s]);
      write_reg(REG_GANTRY_Z_LIMIT, limits[s]);
      for (k = 0; k < 8; k++) send_random_frame(FRAME_BYTES);
    end
  endtask

  task automatic test_random_stream();
    int n;
    n = 0;
    while (bytes_sent < 1450) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      send_random_buffer();
      n++;
      if (n % 15 == 0) drain_results();
    end
  endtask

  task automatic test_back_to_back();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    while (bytes_sent < 1650) send_random_buffer();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_modes();
    test_buffer_lengths();
    test_register_extremes();
    test_register_sweep();
    test_random_stream();
    test_back_to_back();
    drain_results();
    if (mismatches == 0 && pending_axes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rcfd_pkg.sv
rtl/rcfd_ctrl.sv
rtl/rcfd_datapath.sv
rtl/rc_frame_decode_axis_mapper_top.sv
rtl/rcfd_checker.sv
tb/sv/rc_frame_decode_axis_mapper_top_test.sv
